// File: src/polynomial_trajectory_generator_macros.svh
// ---------------------------------------------------------------------------
// polynomial trajectory generator assertion macros
// shared property forms for the trajectory generator checks
// ---------------------------------------------------------------------------
`ifndef POLYNOMIAL_TRAJECTORY_GENERATOR_MACROS_SVH
`define POLYNOMIAL_TRAJECTORY_GENERATOR_MACROS_SVH

// same-cycle implication
`define PTG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PTG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/ptg_pkg.sv
// ---------------------------------------------------------------------------
// ptg_pkg
// constants and register codes of the polynomial trajectory generator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptg_pkg;

	localparam int FRAC_BITS = 16;
	localparam int S_BITS    = 24;
	localparam int S_W       = S_BITS + 1;
	localparam int TIME_W    = 24;
	localparam int DATA_W    = 32;
	localparam int IDX_W     = 3;

	localparam int DIV_N     = S_W;
	localparam int ACC_W     = 56;

	localparam int CF1_XW    = 40;
	localparam int CF1_OW    = CF1_XW + TIME_W - FRAC_BITS + 1;
	localparam int CF2_XW    = CF1_OW + 1;
	localparam int CF2_OW    = CF2_XW + TIME_W - FRAC_BITS + 1;
	localparam int HM_OW     = ACC_W + S_W - S_BITS + 1;
	localparam int P_W       = HM_OW + 2;

	localparam logic [S_W-1:0]    S_ONE        = S_W'(1) << S_BITS;
	localparam logic [TIME_W-1:0] DURATION_RST = TIME_W'(65536);

	localparam logic [IDX_W-1:0] REG_MODE      = 3'd0;
	localparam logic [IDX_W-1:0] REG_START_POS = 3'd1;
	localparam logic [IDX_W-1:0] REG_END_POS   = 3'd2;
	localparam logic [IDX_W-1:0] REG_START_VEL = 3'd3;
	localparam logic [IDX_W-1:0] REG_END_VEL   = 3'd4;
	localparam logic [IDX_W-1:0] REG_START_ACC = 3'd5;
	localparam logic [IDX_W-1:0] REG_END_ACC   = 3'd6;
	localparam logic [IDX_W-1:0] REG_DURATION  = 3'd7;

endpackage

// File: src/ptg_mulsh.sv
// ---------------------------------------------------------------------------
// ptg_mulsh
// three-stage signed by unsigned scaled multiply, round half away from zero
// result is magnitude and sign of round(x * m / 2^SH)
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptg_mulsh #(
	parameter int XW = 40,
	parameter int MW = 24,
	parameter int SH = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [XW-1:0] x,
	input  logic [MW-1:0]        m,
	output logic [XW+MW-SH:0]    mag,
	output logic                 neg
);

	localparam int LO    = (XW + 1) / 2;
	localparam int HI    = XW - LO;
	localparam int SUM_W = XW + MW + 1;

	logic [XW-1:0]      mag_s1;
	logic [MW-1:0]      m_s1;
	logic               neg_s1;
	logic [HI+MW-1:0]   ph_s2;
	logic [LO+MW-1:0]   pl_s2;
	logic               neg_s2;
	logic [XW+MW-SH:0]  mag_s3;
	logic               neg_s3;
	logic [SUM_W-1:0]   full;

	assign full = (SUM_W'(ph_s2) << LO) + SUM_W'(pl_s2) + (SUM_W'(1) << (SH - 1));

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= x[XW-1];
			mag_s1 <= x[XW-1] ? XW'(-x) : XW'(x);
			m_s1   <= m;
			ph_s2  <= mag_s1[XW-1:LO] * m_s1;
			pl_s2  <= mag_s1[LO-1:0] * m_s1;
			neg_s2 <= neg_s1;
			mag_s3 <= full[SUM_W-1:SH];
			neg_s3 <= neg_s2;
		end
	end

	assign mag = mag_s3;
	assign neg = neg_s3;

endmodule

// File: src/polynomial_trajectory_generator.sv
// ---------------------------------------------------------------------------
// polynomial trajectory generator
// evaluates a cubic or quintic point-to-point move at each sample time
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_we                 cfg_index, cfg_data
//   in       in         in_valid / in_stall    sample_time
//   out      out        out_valid / out_stall  position, at_end
//
// one beat per cycle while not stalled, 48 register stages from input to output
// the time fraction comes from a 25-stage divider, one quotient bit a stage
// coefficients are rebuilt by a free-running register pipe after a register write, off the beat path
// reset clears the registers to their defaults and empties the pipe
// a stalled output beat freezes every beat pipe stage, in_stall follows it
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "polynomial_trajectory_generator_macros.svh"

module polynomial_trajectory_generator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ptg_pkg::IDX_W-1:0]      cfg_index,
	input  logic [ptg_pkg::DATA_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [ptg_pkg::TIME_W-1:0]     sample_time,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [ptg_pkg::DATA_W-1:0] position,
	output logic                           at_end
);

	localparam int TW     = ptg_pkg::TIME_W;
	localparam int DW     = ptg_pkg::DATA_W;
	localparam int AW     = ptg_pkg::ACC_W;
	localparam int SW     = ptg_pkg::S_W;
	localparam int DIV_N  = ptg_pkg::DIV_N;
	localparam int C1X    = ptg_pkg::CF1_XW;
	localparam int C1O    = ptg_pkg::CF1_OW;
	localparam int C2X    = ptg_pkg::CF2_XW;
	localparam int C2O    = ptg_pkg::CF2_OW;
	localparam int HMO    = ptg_pkg::HM_OW;
	localparam int PW     = ptg_pkg::P_W;
	localparam int PIPE_N = DIV_N + 22;

	localparam logic signed [PW-1:0] P_HI = PW'(64'sh000000007FFFFFFF);
	localparam logic signed [PW-1:0] P_LO = PW'(-64'sh0000000080000000);

	// configuration registers
	logic                 mode_q;
	logic signed [DW-1:0] start_pos_q, end_pos_q, start_vel_q, end_vel_q;
	logic signed [DW-1:0] start_acc_q, end_acc_q;
	logic [TW-1:0]        duration_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= 1'b0;
			start_pos_q <= '0;
			end_pos_q   <= '0;
			start_vel_q <= '0;
			end_vel_q   <= '0;
			start_acc_q <= '0;
			end_acc_q   <= '0;
			duration_q  <= ptg_pkg::DURATION_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ptg_pkg::REG_MODE:      mode_q      <= cfg_data[0];
				ptg_pkg::REG_START_POS: start_pos_q <= cfg_data;
				ptg_pkg::REG_END_POS:   end_pos_q   <= cfg_data;
				ptg_pkg::REG_START_VEL: start_vel_q <= cfg_data;
				ptg_pkg::REG_END_VEL:   end_vel_q   <= cfg_data;
				ptg_pkg::REG_START_ACC: start_acc_q <= cfg_data;
				ptg_pkg::REG_END_ACC:   end_acc_q   <= cfg_data;
				ptg_pkg::REG_DURATION: begin
					// zero duration acts as one
					duration_q <= (cfg_data[TW-1:0] == '0) ? TW'(1) : cfg_data[TW-1:0];
				end
				default: ;
			endcase
		end
	end

	// coefficient pipe, free running off the registers
	logic signed [32:0]    cf_h_s1;
	logic signed [C1X-1:0] cf_lin_s1 [0:9];
	logic [C1O-1:0]        cf_m1_mag [0:9];
	logic                  cf_m1_neg [0:9];
	logic signed [C2X-1:0] cf_t_s5   [0:9];
	logic [C2O-1:0]        cf_m2_mag [0:3];
	logic                  cf_m2_neg [0:3];
	logic signed [AW-1:0]  cf_tt_s9  [0:3];
	logic signed [AW-1:0]  cf_e_s10  [1:5];
	logic signed [AW-1:0]  e_d       [1:5];
	logic signed [C1X-1:0] vi_x, vf_x, ai_x, af_x;
	logic signed [AW-1:0]  hx;
	logic signed [AW-1:0]  tvx [0:5];
	logic signed [C2O:0]   tt_w [0:3];

	assign vi_x = C1X'(start_vel_q);
	assign vf_x = C1X'(end_vel_q);
	assign ai_x = C1X'(start_acc_q);
	assign af_x = C1X'(end_acc_q);

	always_ff @(posedge clk) begin
		cf_h_s1      <= 33'(end_pos_q) - 33'(start_pos_q);
		cf_lin_s1[0] <= vi_x;
		cf_lin_s1[1] <= vi_x * C1X'(2) + vf_x;
		cf_lin_s1[2] <= vi_x + vf_x;
		cf_lin_s1[3] <= vf_x * C1X'(8) + vi_x * C1X'(12);
		cf_lin_s1[4] <= vf_x * C1X'(14) + vi_x * C1X'(16);
		cf_lin_s1[5] <= (vf_x + vi_x) * C1X'(6);
		cf_lin_s1[6] <= ai_x;
		cf_lin_s1[7] <= ai_x * C1X'(3) - af_x;
		cf_lin_s1[8] <= ai_x * C1X'(3) - af_x * C1X'(2);
		cf_lin_s1[9] <= ai_x - af_x;
	end

	for (genvar i = 0; i < 10; i++) begin : g_cf1
		ptg_mulsh #(.XW(C1X), .MW(TW), .SH(ptg_pkg::FRAC_BITS)) u_mul (
			.clk (clk),
			.en  (1'b1),
			.x   (cf_lin_s1[i]),
			.m   (duration_q),
			.mag (cf_m1_mag[i]),
			.neg (cf_m1_neg[i])
		);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 10; i++) begin
			cf_t_s5[i] <= cf_m1_neg[i] ? -signed'(C2X'(cf_m1_mag[i]))
			                           : signed'(C2X'(cf_m1_mag[i]));
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_cf2
		ptg_mulsh #(.XW(C2X), .MW(TW), .SH(ptg_pkg::FRAC_BITS)) u_mul (
			.clk (clk),
			.en  (1'b1),
			.x   (cf_t_s5[6+i]),
			.m   (duration_q),
			.mag (cf_m2_mag[i]),
			.neg (cf_m2_neg[i])
		);
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			tt_w[i] = cf_m2_neg[i] ? -signed'((C2O+1)'(cf_m2_mag[i]))
			                       : signed'((C2O+1)'(cf_m2_mag[i]));
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			cf_tt_s9[i] <= tt_w[i][AW-1:0];
		end
	end

	always_comb begin
		hx = AW'(cf_h_s1);
		for (int i = 0; i < 6; i++) begin
			tvx[i] = AW'(cf_t_s5[i]);
		end
		e_d[1] = tvx[0] * AW'(2);
		if (mode_q) begin
			e_d[2] = cf_tt_s9[0];
			e_d[3] = hx * AW'(20) - tvx[3] - cf_tt_s9[1];
			e_d[4] = tvx[4] + cf_tt_s9[2] - hx * AW'(30);
			e_d[5] = hx * AW'(12) - tvx[5] - cf_tt_s9[3];
		end else begin
			e_d[2] = (hx * AW'(3) - tvx[1]) * AW'(2);
			e_d[3] = (tvx[2] - hx * AW'(2)) * AW'(2);
			e_d[4] = '0;
			e_d[5] = '0;
		end
	end

	always_ff @(posedge clk) begin
		cf_e_s10 <= e_d;
	end

	// beat pipe
	logic               en;
	logic [PIPE_N:1]    vld_s;
	logic [PIPE_N:1]    end_s;
	logic [TW-1:0]      t_s1;
	logic               out_valid_q;
	logic signed [DW-1:0] position_q;
	logic               at_end_q;

	assign en       = !(out_valid_q && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s       <= {vld_s[PIPE_N-1:1], in_valid};
			out_valid_q <= vld_s[PIPE_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			end_s <= {end_s[PIPE_N-1:1], sample_time > duration_q};
			t_s1  <= (sample_time > duration_q) ? duration_q : sample_time;
		end
	end

	// restoring divider for round(t * 2^24 / d)
	logic [TW-1:0] dv_rem_s [1:DIV_N];
	logic [SW-1:0] dv_num_s [1:DIV_N];
	logic [SW-1:0] dv_quo_s [1:DIV_N];
	logic [TW-1:0] rem_in   [1:DIV_N];
	logic [SW-1:0] num_in   [1:DIV_N];
	logic [SW-1:0] quo_in   [1:DIV_N];
	logic [SW-1:0] trial    [1:DIV_N];
	logic          geq      [1:DIV_N];

	always_comb begin
		for (int k = 1; k <= DIV_N; k++) begin
			if (k == 1) begin
				rem_in[k] = {1'b0, t_s1[TW-1:1]};
				num_in[k] = {t_s1[0], 1'b0, duration_q[TW-1:1]};
				quo_in[k] = '0;
			end else begin
				rem_in[k] = dv_rem_s[k-1];
				num_in[k] = dv_num_s[k-1];
				quo_in[k] = dv_quo_s[k-1];
			end
			trial[k] = {rem_in[k], num_in[k][SW-1]};
			geq[k]   = trial[k] >= {1'b0, duration_q};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 1; k <= DIV_N; k++) begin
				dv_rem_s[k] <= geq[k] ? TW'(trial[k] - {1'b0, duration_q}) : trial[k][TW-1:0];
				dv_num_s[k] <= {num_in[k][SW-2:0], 1'b0};
				dv_quo_s[k] <= {quo_in[k][SW-2:0], geq[k]};
			end
		end
	end

	// horner evaluation, five scaled multiplies
	logic [SW-1:0]        sl_s  [1:16];
	logic signed [AW-1:0] acc_s [1:4];
	logic signed [AW-1:0] hx_in [1:5];
	logic [SW-1:0]        hm_in [1:5];
	logic [HMO-1:0]       h_mag [1:5];
	logic                 h_neg [1:5];
	logic signed [HMO:0]  acc_w [1:4];
	logic [HMO-1:0]       hm_s;
	logic                 hn_s;
	logic signed [PW-1:0] p_s;

	always_ff @(posedge clk) begin
		if (en) begin
			sl_s[1] <= dv_quo_s[DIV_N];
			for (int i = 2; i <= 16; i++) begin
				sl_s[i] <= sl_s[i-1];
			end
		end
	end

	always_comb begin
		hx_in[1] = cf_e_s10[5];
		hm_in[1] = dv_quo_s[DIV_N];
		for (int j = 2; j <= 5; j++) begin
			hx_in[j] = acc_s[j-1];
			hm_in[j] = sl_s[4*(j-1)];
		end
		for (int j = 1; j <= 4; j++) begin
			acc_w[j] = h_neg[j] ? (HMO+1)'(cf_e_s10[5-j]) - signed'((HMO+1)'(h_mag[j]))
			                    : (HMO+1)'(cf_e_s10[5-j]) + signed'((HMO+1)'(h_mag[j]));
		end
	end

	for (genvar j = 1; j <= 5; j++) begin : g_horner
		ptg_mulsh #(.XW(AW), .MW(SW), .SH(ptg_pkg::S_BITS)) u_mul (
			.clk (clk),
			.en  (en),
			.x   (hx_in[j]),
			.m   (hm_in[j]),
			.mag (h_mag[j]),
			.neg (h_neg[j])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 1; j <= 4; j++) begin
				acc_s[j] <= acc_w[j][AW-1:0];
			end
			hm_s <= HMO'(((HMO+1)'(h_mag[5]) + (HMO+1)'(1)) >> 1);
			hn_s <= h_neg[5];
			p_s  <= hn_s ? PW'(start_pos_q) - signed'(PW'(hm_s))
			             : PW'(start_pos_q) + signed'(PW'(hm_s));
		end
	end

	// output register with saturation
	always_ff @(posedge clk) begin
		if (en) begin
			at_end_q <= end_s[PIPE_N];
			if (p_s > P_HI) begin
				position_q <= P_HI[DW-1:0];
			end else if (p_s < P_LO) begin
				position_q <= P_LO[DW-1:0];
			end else begin
				position_q <= p_s[DW-1:0];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign position  = position_q;
	assign at_end    = at_end_q;

	// checks
	`PTG_ASSERT_NOW(a_quo_range, clk, arst_n, vld_s[DIV_N+1], dv_quo_s[DIV_N] <= ptg_pkg::S_ONE, "time fraction above one")
	`PTG_ASSERT_NOW(a_quo_clamp, clk, arst_n, vld_s[DIV_N+1] && end_s[DIV_N+1], dv_quo_s[DIV_N] == ptg_pkg::S_ONE, "clamped beat fraction not one")
	`PTG_ASSERT_NOW(a_rem_range, clk, arst_n, vld_s[DIV_N+1], dv_rem_s[DIV_N] < duration_q, "divider remainder not below duration")
	`PTG_ASSERT_NEXT(a_end_flag, clk, arst_n, in_valid && !in_stall && sample_time > duration_q, vld_s[1] && end_s[1], "clamp flag lost at entry")

endmodule
